// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define QJT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define QJT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/qjt_pkg.sv =====
package qjt_pkg;

  // normalized time: unsigned Q1.24, saturates at exactly 1.0
  localparam int TAU_BITS = 24;
  localparam int TAU_W    = TAU_BITS + 1;
  localparam logic [TAU_W-1:0] TAU_ONE = TAU_W'(1) << TAU_BITS;

  // shape polynomial arithmetic
  localparam int POLY_W = 36;
  localparam int SHP_W  = 29;   // magnitude of s, s' and s''
  localparam int D_W    = 33;   // magnitude of end - start
  localparam int D_LO   = 17;
  localparam int MAG_W  = 39;   // rounded magnitude of D * shape
  localparam int MAG_LO = 20;

  localparam int STAGES = 10;

  localparam logic signed [POLY_W-1:0] K_S3   = 36'sd10;
  localparam logic signed [POLY_W-1:0] K_S4   = 36'sd15;
  localparam logic signed [POLY_W-1:0] K_S5   = 36'sd6;
  localparam logic signed [POLY_W-1:0] K_V2   = 36'sd30;
  localparam logic signed [POLY_W-1:0] K_V3   = 36'sd60;
  localparam logic signed [POLY_W-1:0] K_V4   = 36'sd30;
  localparam logic signed [POLY_W-1:0] K_A1   = 36'sd60;
  localparam logic signed [POLY_W-1:0] K_A2   = 36'sd180;
  localparam logic signed [POLY_W-1:0] K_A3   = 36'sd120;

  typedef enum logic [1:0] {
    CFG_TAU_INC   = 2'd0,
    CFG_STEP_TIME = 2'd1,
    CFG_INV_T     = 2'd2,
    CFG_INV_T2    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0]        step_index;
    logic signed [31:0] start_position;
    logic signed [31:0] end_position;
    logic signed [31:0] lower_limit;
    logic signed [31:0] upper_limit;
  } in_t;

  typedef struct packed {
    logic [31:0]        sample_time;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic               clamped;
  } out_t;

  typedef struct packed {
    logic en_a;
    logic en_b;
    logic zero;
  } scl_ctl_t;

endpackage

// ===== design/qjt_tmul.sv =====
// One registered power step: y = round(a * t / 2^24), a and t in Q1.24.
module qjt_tmul (
  input  logic                      clk,
  input  logic                      en,
  input  logic [qjt_pkg::TAU_W-1:0] a,
  input  logic [qjt_pkg::TAU_W-1:0] t,
  output logic [qjt_pkg::TAU_W-1:0] y
);

  localparam int PW = 2 * qjt_pkg::TAU_W;

  logic [PW-1:0] prod;

  assign prod = PW'(a) * PW'(t) + (PW'(1) << (qjt_pkg::TAU_BITS - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      y <= prod[qjt_pkg::TAU_BITS +: qjt_pkg::TAU_W];
    end
  end

endmodule

// ===== design/qjt_scale.sv =====
// Signed magnitude times an unsigned Q.F factor, rounded and saturated.
// Stage A forms two partial products, B sums, rounds, clips or zeroes.
module qjt_scale #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  qjt_pkg::scl_ctl_t         ctl,
  input  logic [qjt_pkg::MAG_W-1:0] mag,
  input  logic                      neg,
  input  logic [31:0]               factor,
  output logic signed [31:0]        res
);

  localparam int LO   = qjt_pkg::MAG_LO;
  localparam int HI   = qjt_pkg::MAG_W - qjt_pkg::MAG_LO;
  localparam int PL_W = LO + 32;
  localparam int PH_W = HI + 32;
  localparam int PW   = qjt_pkg::MAG_W + 32;

  logic [PL_W-1:0] pl;
  logic [PH_W-1:0] ph;
  logic            neg_a;

  logic [PW-1:0] prod;
  logic [PW-1:0] rnd;
  logic          big;

  always_ff @(posedge clk) begin
    if (ctl.en_a) begin
      pl    <= PL_W'(mag[LO-1:0]) * PL_W'(factor);
      ph    <= PH_W'(mag[qjt_pkg::MAG_W-1:LO]) * PH_W'(factor);
      neg_a <= neg;
    end
  end

  always_comb begin
    prod = (PW'(ph) << LO) + PW'(pl);
    rnd  = (prod + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    big  = |rnd[PW-1:31];
  end

  always_ff @(posedge clk) begin
    if (ctl.en_b) begin
      if (ctl.zero) begin
        res <= '0;
      end else if (big) begin
        res <= neg_a ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        res <= neg_a ? -$signed(rnd[31:0]) : $signed(rnd[31:0]);
      end
    end
  end

endmodule

// ===== design/quintic_joint_trajectory_point.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    in_data (qjt_pkg::in_t)
// out       output     out_valid/out_ready  out_data (qjt_pkg::out_t)
// cfg       input      cfg_write            cfg_index, cfg_data
//
// Ten register stages; one beat in per cycle while the output is not stalled.
// The stage count is set by the chain t^2..t^5 (four serial multiplies) and the
// split wide products that follow.
// Every stage has its own valid bit; a stalled output holds the pipe back
// stage by stage, filling bubbles, so nothing is lost or repeated.
// Synchronous reset clears the valid bits and loads the register defaults.
`include "assert_macros.svh"

module quintic_joint_trajectory_point #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  qjt_pkg::in_t         in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output qjt_pkg::out_t        out_data,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int N    = qjt_pkg::STAGES;
  localparam int TW   = qjt_pkg::TAU_W;
  localparam int PW   = qjt_pkg::POLY_W;
  localparam int SW   = qjt_pkg::SHP_W;
  localparam int DW   = qjt_pkg::D_W;
  localparam int DL   = qjt_pkg::D_LO;
  localparam int MW   = qjt_pkg::MAG_W;
  localparam int PPL  = DL + SW;
  localparam int PPH  = DW - DL + SW;
  localparam int PRW  = DW + SW + 1;

  typedef struct packed {
    logic [31:0]        ts;
    logic signed [31:0] q0;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [DW-1:0]      dmag;
    logic               dneg;
  } side_t;

  // configuration
  logic [TW-1:0] tau_inc;
  logic [31:0]   step_time;
  logic [31:0]   inv_t;
  logic [31:0]   inv_t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      tau_inc   <= TW'(167772);
      step_time <= 32'd655;
      inv_t     <= 32'd65536;
      inv_t2    <= 32'd65536;
    end else if (cfg_write) begin
      case (qjt_pkg::cfg_idx_t'(cfg_index))
        qjt_pkg::CFG_TAU_INC:   tau_inc   <= cfg_data[TW-1:0];
        qjt_pkg::CFG_STEP_TIME: step_time <= cfg_data;
        qjt_pkg::CFG_INV_T:     inv_t     <= cfg_data;
        qjt_pkg::CFG_INV_T2:    inv_t2    <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [N-1:0] vld;
  logic [N-1:0] en;

  always_comb begin
    en[N-1] = ~vld[N-1] | out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < N; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // side data that rides along
  side_t side [N-1];
  side_t side_in;

  logic [47:0]        ts_full;
  logic signed [DW-1:0] d_in;

  always_comb begin
    ts_full      = 48'(in_data.step_index) * 48'(step_time);
    d_in         = $signed({in_data.end_position[31], in_data.end_position})
                 - $signed({in_data.start_position[31], in_data.start_position});
    side_in.ts   = (|ts_full[47:32]) ? '1 : ts_full[31:0];
    side_in.q0   = in_data.start_position;
    side_in.lo   = in_data.lower_limit;
    side_in.hi   = in_data.upper_limit;
    side_in.dneg = d_in[DW-1];
    side_in.dmag = d_in[DW-1] ? DW'(-d_in) : DW'(d_in);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side[0] <= side_in;
    end
    for (int k = 1; k < N - 1; k++) begin
      if (en[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  // stage 0: raw normalized time
  logic [40:0] t_raw0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_raw0 <= 41'(in_data.step_index) * 41'(tau_inc);
    end
  end

  // stages 1..4: powers of t
  logic [TW-1:0] t_sat;
  logic [TW-1:0] t_1, t_2, t_3, t_4;
  logic [TW-1:0] t2_1, t2_2, t2_3, t2_4;
  logic [TW-1:0] t3_2, t3_3, t3_4;
  logic [TW-1:0] t4_3, t4_4;
  logic [TW-1:0] t5_4;

  assign t_sat = (t_raw0 > 41'(qjt_pkg::TAU_ONE)) ? qjt_pkg::TAU_ONE : t_raw0[TW-1:0];

  qjt_tmul u_t2 (.clk(clk), .en(en[1]), .a(t_sat), .t(t_sat), .y(t2_1));
  qjt_tmul u_t3 (.clk(clk), .en(en[2]), .a(t2_1),  .t(t_1),   .y(t3_2));
  qjt_tmul u_t4 (.clk(clk), .en(en[3]), .a(t3_2),  .t(t_2),   .y(t4_3));
  qjt_tmul u_t5 (.clk(clk), .en(en[4]), .a(t4_3),  .t(t_3),   .y(t5_4));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      t_1 <= t_sat;
    end
    if (en[2]) begin
      t_2  <= t_1;
      t2_2 <= t2_1;
    end
    if (en[3]) begin
      t_3  <= t_2;
      t2_3 <= t2_2;
      t3_3 <= t3_2;
    end
    if (en[4]) begin
      t_4  <= t_3;
      t2_4 <= t2_3;
      t3_4 <= t3_3;
      t4_4 <= t4_3;
    end
  end

  // stage 5: shape magnitudes s, s', s'' and the sign of their product with D
  logic signed [PW-1:0] e1, e2, e3, e4, e5;
  logic signed [PW-1:0] shp [3];
  logic signed [PW-1:0] shp_abs [3];
  logic [SW-1:0]        shp_mag5 [3];
  logic [2:0]           shp_neg5;

  always_comb begin
    e1 = $signed(PW'(t_4));
    e2 = $signed(PW'(t2_4));
    e3 = $signed(PW'(t3_4));
    e4 = $signed(PW'(t4_4));
    e5 = $signed(PW'(t5_4));
    shp[0] = qjt_pkg::K_S3 * e3 - qjt_pkg::K_S4 * e4 + qjt_pkg::K_S5 * e5;
    shp[1] = qjt_pkg::K_V2 * e2 - qjt_pkg::K_V3 * e3 + qjt_pkg::K_V4 * e4;
    shp[2] = qjt_pkg::K_A1 * e1 - qjt_pkg::K_A2 * e2 + qjt_pkg::K_A3 * e3;
    for (int j = 0; j < 3; j++) begin
      shp_abs[j] = shp[j][PW-1] ? -shp[j] : shp[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int j = 0; j < 3; j++) begin
        shp_mag5[j] <= shp_abs[j][SW-1:0];
        shp_neg5[j] <= shp[j][PW-1] ^ side[4].dneg;
      end
    end
  end

  // stage 6: partial products of |D| split in two halves
  logic [PPL-1:0] pl6 [3];
  logic [PPH-1:0] ph6 [3];
  logic [2:0]     neg6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int j = 0; j < 3; j++) begin
        pl6[j] <= PPL'(side[5].dmag[DL-1:0]) * PPL'(shp_mag5[j]);
        ph6[j] <= PPH'(side[5].dmag[DW-1:DL]) * PPH'(shp_mag5[j]);
      end
      neg6 <= shp_neg5;
    end
  end

  // stage 7: sum and round to Q.F
  logic [PRW-1:0] prod7 [3];
  logic [MW-1:0]  mag7 [3];
  logic [2:0]     neg7;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      prod7[j] = (PRW'(ph6[j]) << DL) + PRW'(pl6[j])
               + (PRW'(1) << (qjt_pkg::TAU_BITS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int j = 0; j < 3; j++) begin
        mag7[j] <= prod7[j][qjt_pkg::TAU_BITS +: MW];
      end
      neg7 <= neg6;
    end
  end

  // stage 8: unclamped position
  logic signed [MW+1:0] pofs;
  logic signed [MW+1:0] p8;

  assign pofs = neg7[0] ? -$signed((MW+2)'(mag7[0])) : $signed((MW+2)'(mag7[0]));

  always_ff @(posedge clk) begin
    if (en[8]) begin
      p8 <= (MW+2)'(side[7].q0) + pofs;
    end
  end

  // stage 9: clamp
  logic                 below, above, clamp_next;
  logic [31:0]          ts9;
  logic signed [31:0]   pos9;
  logic                 clamp9;
  logic signed [31:0]   vel9, acc9;

  always_comb begin
    below      = p8 < (MW+2)'(side[8].lo);
    above      = (MW+2)'(side[8].hi) < p8;
    clamp_next = below | above;
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      ts9    <= side[8].ts;
      clamp9 <= clamp_next;
      if (below) begin
        pos9 <= side[8].lo;
      end else if (above) begin
        pos9 <= side[8].hi;
      end else begin
        pos9 <= p8[31:0];
      end
    end
  end

  // stages 8 and 9: scale by 1/T and 1/T^2
  qjt_pkg::scl_ctl_t scl_ctl;

  assign scl_ctl.en_a = en[8];
  assign scl_ctl.en_b = en[9];
  assign scl_ctl.zero = clamp_next;

  qjt_scale #(.FRAC_BITS(FRAC_BITS)) u_vel (
    .clk(clk), .ctl(scl_ctl), .mag(mag7[1]), .neg(neg7[1]), .factor(inv_t), .res(vel9)
  );

  qjt_scale #(.FRAC_BITS(FRAC_BITS)) u_acc (
    .clk(clk), .ctl(scl_ctl), .mag(mag7[2]), .neg(neg7[2]), .factor(inv_t2), .res(acc9)
  );

  assign out_data.sample_time  = ts9;
  assign out_data.position     = pos9;
  assign out_data.velocity     = vel9;
  assign out_data.acceleration = acc9;
  assign out_data.clamped      = clamp9;

  `QJT_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid, "output valid after reset")
  `QJT_ASSERT(a_clamp_zero, out_valid && clamp9 |-> (vel9 | acc9) == '0, "clamped beat moving")
  `QJT_ASSERT(a_last_move, vld[N-2] && en[N-1] |=> out_valid, "beat lost entering output stage")
  `QJT_ASSERT(a_full_stall, (&vld) && !out_ready |-> !in_ready, "full pipe took a beat while stalled")

endmodule

// ===== bench/qjt_setpoint_checker.sv =====
module qjt_setpoint_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  qjt_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  qjt_pkg::out_t out_data,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output int            errors,
  output int            pending
);

  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  longint unsigned tau_inc, step_time, inv_t, inv_t2;
  qjt_pkg::out_t expected_setpoints[$];
  qjt_pkg::out_t got, want;

  task automatic report(input string what, input logic [31:0] seen, input logic [31:0] wanted);
    if (errors < 40) begin
      $display("%0t setpoint mismatch: %s got %h want %h", $time, what, seen, wanted);
    end
    errors++;
  endtask

  // round to nearest, halves away from zero
  function automatic longint round_shift(longint x, int n);
    longint unsigned m;
    m = (x < 0) ? -x : x;
    m = (m + (64'd1 << (n - 1))) >> n;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned tau_mul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << (qjt_pkg::TAU_BITS - 1))) >> qjt_pkg::TAU_BITS;
  endfunction

  // signed Q.F times unsigned Q.F, magnitude capped at 2^32 before the sign
  function automatic longint scale_sat(longint x, longint unsigned k);
    logic [79:0] m;
    longint r;
    m = (x < 0) ? 80'(-x) : 80'(x);
    m = (m * 80'(k) + (80'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (m > (80'd1 << 32)) m = 80'd1 << 32;
    r = (x < 0) ? -longint'(m[63:0]) : longint'(m[63:0]);
    if (r > I32_MAX) r = I32_MAX;
    else if (r < I32_MIN) r = I32_MIN;
    return r;
  endfunction

  function automatic qjt_pkg::out_t predict_setpoint(qjt_pkg::in_t x);
    longint unsigned ts, t1, t2, t3, t4, t5;
    longint s, ds, dds, d, p, v, a, pc;
    qjt_pkg::out_t r;
    ts = 64'(x.step_index) * step_time;
    t1 = 64'(x.step_index) * tau_inc;
    if (t1 > (64'd1 << qjt_pkg::TAU_BITS)) t1 = 64'd1 << qjt_pkg::TAU_BITS;
    t2 = tau_mul(t1, t1);
    t3 = tau_mul(t2, t1);
    t4 = tau_mul(t3, t1);
    t5 = tau_mul(t4, t1);
    s   = 10 * longint'(t3) - 15 * longint'(t4) + 6 * longint'(t5);
    ds  = 30 * longint'(t2) - 60 * longint'(t3) + 30 * longint'(t4);
    dds = 60 * longint'(t1) - 180 * longint'(t2) + 120 * longint'(t3);
    d = longint'(x.end_position) - longint'(x.start_position);
    p = longint'(x.start_position) + round_shift(d * s, qjt_pkg::TAU_BITS);
    v = scale_sat(round_shift(d * ds, qjt_pkg::TAU_BITS), inv_t);
    a = scale_sat(round_shift(d * dds, qjt_pkg::TAU_BITS), inv_t2);
    // lower checked first; crossed limits give lower only for p below it
    if (p < longint'(x.lower_limit)) pc = x.lower_limit;
    else if (longint'(x.upper_limit) < p) pc = x.upper_limit;
    else pc = p;
    r.clamped = (pc != p);
    if (r.clamped) begin
      v = 0;
      a = 0;
    end
    r.sample_time  = (ts > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ts[31:0];
    r.position     = pc[31:0];
    r.velocity     = v[31:0];
    r.acceleration = a[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      tau_inc   = 167772;
      step_time = 655;
      inv_t     = 65536;
      inv_t2    = 65536;
      errors    = 0;
      expected_setpoints.delete();
    end else begin
      if (cfg_write) begin
        case (qjt_pkg::cfg_idx_t'(cfg_index))
          qjt_pkg::CFG_TAU_INC:   tau_inc = cfg_data[24:0];
          qjt_pkg::CFG_STEP_TIME: step_time = cfg_data;
          qjt_pkg::CFG_INV_T:     inv_t = cfg_data;
          qjt_pkg::CFG_INV_T2:    inv_t2 = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_setpoints = {expected_setpoints, predict_setpoint(in_data)};
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_setpoints.size() == 0) begin
          report("result beat with nothing expected", got.position, '0);
        end else begin
          want = expected_setpoints.pop_front();
          if (got.sample_time !== want.sample_time)
            report("sample_time", got.sample_time, want.sample_time);
          if (got.position !== want.position)
            report("position", got.position, want.position);
          if (got.velocity !== want.velocity)
            report("velocity", got.velocity, want.velocity);
          if (got.acceleration !== want.acceleration)
            report("acceleration", got.acceleration, want.acceleration);
          if (got.clamped !== want.clamped)
            report("clamped", 32'(got.clamped), 32'(want.clamped));
        end
      end
    end
    pending = expected_setpoints.size();
  end

endmodule

// ===== bench/tb.sv =====
module tb;

  localparam int FRAC    = 16;
  localparam int ONE     = 65536;
  localparam int POS_MIN = 32'sh8000_0000;
  localparam int POS_MAX = 32'sh7FFF_FFFF;

  logic          clk;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  qjt_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  qjt_pkg::out_t out_data;
  logic          cfg_write = 1'b0;
  logic [1:0]    cfg_index = qjt_pkg::CFG_TAU_INC;
  logic [31:0]   cfg_data = '0;
  int            errors;
  int            pending;

  bit              quiet = 1'b0;
  longint unsigned tau_now = 167772;

  quintic_joint_trajectory_point #(.FRAC_BITS(FRAC)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  qjt_setpoint_checker #(.FRAC_BITS(FRAC)) i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400000);
    $display("[quintic_joint_trajectory_point] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 37);
  end

  function automatic qjt_pkg::in_t point(logic [15:0] idx, int q0, int q1, int lo, int hi);
    qjt_pkg::in_t x;
    x.step_index     = idx;
    x.start_position = q0;
    x.end_position   = q1;
    x.lower_limit    = lo;
    x.upper_limit    = hi;
    return x;
  endfunction

  // mostly moves inside the time window with moderate spans; some noise
  function automatic qjt_pkg::in_t random_point(longint unsigned tau);
    qjt_pkg::in_t x;
    longint unsigned span;
    int q0, q1, lo_e, hi_e;
    longint reach;
    span = (tau == 0) ? 65535 : (64'd1 << qjt_pkg::TAU_BITS) / tau + 2;
    if (span > 65535) span = 65535;
    x.step_index = ($urandom_range(99) < 8) ? 16'($urandom) : 16'($urandom_range(int'(span)));
    if ($urandom_range(9) < 2) begin
      x.start_position = $urandom;
      x.end_position   = $urandom;
      x.lower_limit    = $urandom;
      x.upper_limit    = $urandom;
      return x;
    end
    if ($urandom_range(9) < 8) begin
      q0 = int'($urandom_range(4194304)) - 2097152;
      q1 = int'($urandom_range(4194304)) - 2097152;
    end else begin
      q0 = POS_MIN + int'($urandom_range(16777216));
      q1 = POS_MAX - int'($urandom_range(16777216));
      if ($urandom_range(1)) begin
        lo_e = q0;
        q0 = q1;
        q1 = lo_e;
      end
    end
    lo_e = (q0 < q1) ? q0 : q1;
    hi_e = (q0 < q1) ? q1 : q0;
    reach = longint'(hi_e) - longint'(lo_e);
    x.start_position = q0;
    x.end_position   = q1;
    case ($urandom_range(3))
      0: begin
        x.lower_limit = POS_MIN;
        x.upper_limit = POS_MAX;
      end
      1: begin
        x.lower_limit = int'(longint'(lo_e) + longint'($urandom) % (reach / 2 + 1));
        x.upper_limit = int'(longint'(hi_e) - longint'($urandom) % (reach / 2 + 1));
      end
      2: begin
        x.lower_limit = $urandom;
        x.upper_limit = $urandom;
      end
      default: begin
        // crossed limits
        x.lower_limit = int'(longint'(hi_e) - longint'($urandom) % (reach / 4 + 1));
        x.upper_limit = int'(longint'(lo_e) + longint'($urandom) % (reach / 4 + 1));
      end
    endcase
    return x;
  endfunction

  task automatic send_point(input qjt_pkg::in_t x);
    if (!quiet) begin
      while ($urandom_range(99) < 37) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_data  <= x;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] tau, input logic [31:0] st,
                            input logic [31:0] iv, input logic [31:0] iv2);
    cfg_write <= 1'b1;
    cfg_index <= qjt_pkg::CFG_TAU_INC;
    cfg_data  <= tau;
    @(posedge clk);
    cfg_index <= qjt_pkg::CFG_STEP_TIME;
    cfg_data  <= st;
    @(posedge clk);
    cfg_index <= qjt_pkg::CFG_INV_T;
    cfg_data  <= iv;
    @(posedge clk);
    cfg_index <= qjt_pkg::CFG_INV_T2;
    cfg_data  <= iv2;
    @(posedge clk);
    cfg_write <= 1'b0;
    tau_now = tau[24:0];
  endtask

  initial begin
    int n_rand;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 100 steps to the end of the move
    send_point(point(16'd0, 0, ONE, POS_MIN, POS_MAX));
    send_point(point(16'd50, 0, 3 * ONE, POS_MIN, POS_MAX));
    send_point(point(16'd100, POS_MIN, POS_MAX, POS_MIN, POS_MAX));
    send_point(point(16'd101, POS_MAX, POS_MIN, POS_MIN, POS_MAX));
    send_point(point(16'hFFFF, -ONE, ONE, POS_MIN, POS_MAX));
    send_point(point(16'd25, POS_MAX, POS_MIN, POS_MIN, POS_MAX));
    send_point(point(16'd75, POS_MIN, POS_MAX, POS_MIN, POS_MAX));
    send_point(point(16'd50, 0, 10 * ONE, 0, ONE));
    send_point(point(16'd50, 0, -10 * ONE, -ONE, POS_MAX));
    send_point(point(16'd50, 0, 10 * ONE, 8 * ONE, 0));
    send_point(point(16'd30, 12345, 12345, 12345, 12345));
    send_point(point(16'd10, -777, -777, POS_MIN, POS_MAX));
    send_point(point(16'd1, 0, POS_MAX, POS_MIN, POS_MAX));
    send_point(point(16'd0, 100, ONE, 200, POS_MAX));
    send_point(point(16'd100, 0, ONE, POS_MIN, ONE - 1));
    send_point(point(16'd99, ONE, -ONE, -ONE + 1, POS_MAX));

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: set_config(32'd16777216, 32'hFFFF_FFFF, 32'd0, 32'd0);
          2: set_config(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
          3: set_config(32'd131072, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
          4: set_config($urandom_range(16777216, 1), $urandom_range(65536), $urandom, $urandom);
          default: set_config($urandom_range(1048576, 65536), $urandom,
                              $urandom_range(1048576), $urandom_range(4194304));
        endcase
      end
      // one phase runs with both sides flat out
      quiet = (ph == 4);
      send_point(point(16'hFFFF, POS_MIN, POS_MAX, POS_MIN, POS_MAX));
      send_point(point(16'd1, POS_MAX, POS_MIN, POS_MIN, POS_MAX));
      n_rand = (ph == 1 || ph == 2) ? 40 : 80;
      for (int i = 0; i < n_rand; i++) begin
        if (ph == 0 && i == n_rand / 2) drain();
        send_point(random_point(tau_now));
      end
    end

    drain();
    repeat (30) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[quintic_joint_trajectory_point] OK");
    end else begin
      $display("[quintic_joint_trajectory_point] ERROR");
    end
    $finish;
  end

endmodule
